@@ rtl/lcbc_pkg.sv @@
// Shared types, constants and helper functions for the Luhn card brand checker.
// Depends on nothing; every other file in rtl/ imports it.
package lcbc_pkg;

    localparam int CARD_W        = 63;
    localparam int BIN_W         = 64;
    localparam int DIGITS        = 19;
    localparam int BCD_W         = 4 * DIGITS;
    localparam int BITS_PER_STEP = 4;
    localparam int CONV_STEPS    = BIN_W / BITS_PER_STEP;
    localparam int CNT_W         = $clog2(CONV_STEPS);
    localparam int POS_W         = 5;

    localparam logic [POS_W-1:0] LEN_VISA_SHORT = 5'd13;
    localparam logic [POS_W-1:0] LEN_AMEX       = 5'd15;
    localparam logic [POS_W-1:0] LEN_LONG       = 5'd16;

    localparam logic [3:0] LEAD_AMEX   = 4'd3;
    localparam logic [3:0] AMEX_SEC_A  = 4'd4;
    localparam logic [3:0] AMEX_SEC_B  = 4'd7;
    localparam logic [3:0] LEAD_MC     = 4'd5;
    localparam logic [3:0] MC_SEC_LO   = 4'd1;
    localparam logic [3:0] MC_SEC_HI   = 4'd5;
    localparam logic [3:0] LEAD_VISA   = 4'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_START,
        ST_SCAN,
        ST_FINISH
    } seq_state_t;

    typedef enum logic [1:0] {
        BRAND_INVALID    = 2'd0,
        BRAND_AMEX       = 2'd1,
        BRAND_MASTERCARD = 2'd2,
        BRAND_VISA       = 2'd3
    } brand_t;

    typedef struct packed {
        logic start;
        logic advance;
    } unit_ctrl_t;

    typedef struct packed {
        logic             more;
        logic [POS_W-1:0] count;
        logic [3:0]       top;
        logic [3:0]       second;
        logic             sum_zero;
    } acc_status_t;

    // Doubled Luhn digit with its two decimal digits summed.
    function automatic logic [3:0] luhn_double(logic [3:0] d);
        logic [4:0] t;
        t = {d, 1'b0};
        if (t > 5'd9)
        begin
            t = t - 5'd9;
        end
        return t[3:0];
    endfunction

    function automatic brand_t classify(acc_status_t st);
        brand_t b;
        b = BRAND_INVALID;
        if (st.sum_zero)
        begin
            if (st.count == LEN_AMEX && st.top == LEAD_AMEX &&
                (st.second == AMEX_SEC_A || st.second == AMEX_SEC_B))
            begin
                b = BRAND_AMEX;
            end
            else if (st.count == LEN_LONG && st.top == LEAD_MC &&
                     st.second >= MC_SEC_LO && st.second <= MC_SEC_HI)
            begin
                b = BRAND_MASTERCARD;
            end
            else if (st.top == LEAD_VISA &&
                     (st.count == LEN_VISA_SHORT || st.count == LEN_LONG))
            begin
                b = BRAND_VISA;
            end
        end
        return b;
    endfunction

endpackage

@@ rtl/luhn_card_brand_checker.sv @@
// Top level of the Luhn mod-10 card brand checker: sequencer, output register.
// Depends on lcbc_pkg, lcbc_bcd_conv and lcbc_digit_acc.
//
// Usage:
//   Slave channel (s_tvalid/s_tready/s_tdata) takes one card number per
//   request; s_tdata[62:0] is the number, bit 63 is ignored.
//   Master channel (m_tvalid/m_tready/m_tdata) returns one result per
//   request: brand, decimal digit count and the Luhn check flag.
//   Each request is worked on alone: s_tready is high only while the
//   sequencer is idle. The number is first converted to BCD, four binary
//   bits per cycle, then the digit walker consumes one decimal digit per
//   cycle from the right and stops at the first all-zero remainder.
//   A number has 0 to 19 decimal digits. The next request is taken the
//   cycle after the result is loaded.
//   The result sits in an output register, so a stalled receiver does not
//   stop a new request from being accepted and worked on; only the final
//   load waits until the output register is free or being emptied.
//   Reset (rst_n low, asynchronous) returns the sequencer to idle and drops
//   any pending result.
module luhn_card_brand_checker
    import lcbc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [62:0] card_number, [63] zero fill
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // [1:0] brand, [6:2] digit_count, [7] checksum_ok
);

    seq_state_t        state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    unit_ctrl_t        conv_ctrl;
    unit_ctrl_t        acc_ctrl;
    logic [BCD_W-1:0]  bcd;
    acc_status_t       acc_status;
    logic              load_out;
    logic              out_valid_reg, out_valid_next;
    logic [7:0]        out_data_reg;

    lcbc_bcd_conv u_conv (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (conv_ctrl),
        .value (s_tdata[CARD_W-1:0]),
        .bcd   (bcd)
    );

    lcbc_digit_acc u_acc (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (acc_ctrl),
        .bcd    (bcd),
        .status (acc_status)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        conv_ctrl  = '0;
        acc_ctrl   = '0;
        load_out   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                // Capture the request into the converter.
                if (s_tvalid)
                begin
                    conv_ctrl.start = 1'b1;
                    cnt_next        = '0;
                    state_next      = ST_CONV;
                end
            end
            ST_CONV:
            begin
                conv_ctrl.advance = 1'b1;
                cnt_next          = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(CONV_STEPS - 1))
                begin
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                acc_ctrl.start = 1'b1;
                state_next     = ST_SCAN;
            end
            ST_SCAN:
            begin
                // Advance while nonzero digits remain; zeros above add nothing.
                if (acc_status.more)
                begin
                    acc_ctrl.advance = 1'b1;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                // Hold until the output register frees up.
                if (!out_valid_reg || m_tready)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_data_reg <= {acc_status.sum_zero, acc_status.count, classify(acc_status)};
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // A brand is only ever reported on a number that passed the check.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[1:0] != BRAND_INVALID |-> m_tdata[7])
        else $error("brand reported without a passing checksum");

    // A branded result always has 13, 15 or 16 digits.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[1:0] != BRAND_INVALID |->
            (m_tdata[6:2] == LEN_VISA_SHORT || m_tdata[6:2] == LEN_AMEX ||
             m_tdata[6:2] == LEN_LONG))
        else $error("branded result with an impossible length");

    // The digit count never exceeds what a 63-bit number can hold.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[6:2] <= 5'(DIGITS))
        else $error("digit count out of range");

    // After a request is taken, no second one is taken the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while busy");

endmodule

@@ rtl/lcbc_bcd_conv.sv @@
// Iterative binary to BCD converter (shift and add-3), several bits per cycle.
// Depends on lcbc_pkg.
module lcbc_bcd_conv
    import lcbc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  unit_ctrl_t          ctrl,
    input  logic [CARD_W-1:0]   value,
    output logic [BCD_W-1:0]    bcd
);

    logic [BCD_W-1:0] bcd_reg, bcd_next;
    logic [BIN_W-1:0] bin_reg, bin_next;

    // One step: adjust every digit, shift in the next binary bit, repeat.
    always_comb
    begin
        bcd_next = bcd_reg;
        bin_next = bin_reg;
        for (int b = 0; b < BITS_PER_STEP; b++)
        begin
            for (int k = 0; k < DIGITS; k++)
            begin
                if (bcd_next[4*k +: 4] >= 4'd5)
                begin
                    bcd_next[4*k +: 4] = bcd_next[4*k +: 4] + 4'd3;
                end
            end
            {bcd_next, bin_next} = {bcd_next[BCD_W-2:0], bin_next, 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bcd_reg <= '0;
            bin_reg <= '0;
        end
        else if (ctrl.start)
        begin
            bcd_reg <= '0;
            bin_reg <= {1'b0, value};
        end
        else if (ctrl.advance)
        begin
            bcd_reg <= bcd_next;
            bin_reg <= bin_next;
        end
    end

    assign bcd = bcd_reg;

endmodule

@@ rtl/lcbc_digit_acc.sv @@
// Digit walker: takes BCD digits from the right one per cycle, keeps the Luhn
// sum modulo ten, the digit count and the two leading digits. Depends on lcbc_pkg.
module lcbc_digit_acc
    import lcbc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  unit_ctrl_t        ctrl,
    input  logic [BCD_W-1:0]  bcd,
    output acc_status_t       status
);

    logic [BCD_W-1:0] scan_reg;
    logic [3:0]       sum_reg, sum_next;
    logic [3:0]       prev_reg;
    logic [3:0]       top_reg;
    logic [3:0]       second_reg;
    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] count_reg;
    logic [3:0]       digit;
    logic [3:0]       addend;
    logic [4:0]       sum_wide;

    assign digit  = scan_reg[3:0];
    assign addend = pos_reg[0] ? luhn_double(digit) : digit;

    always_comb
    begin
        sum_wide = {1'b0, sum_reg} + {1'b0, addend};
        if (sum_wide >= 5'd10)
        begin
            sum_wide = sum_wide - 5'd10;
        end
        sum_next = sum_wide[3:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_reg   <= '0;
            sum_reg    <= '0;
            prev_reg   <= '0;
            top_reg    <= '0;
            second_reg <= '0;
            pos_reg    <= '0;
            count_reg  <= '0;
        end
        else if (ctrl.start)
        begin
            scan_reg   <= bcd;
            sum_reg    <= '0;
            prev_reg   <= '0;
            top_reg    <= '0;
            second_reg <= '0;
            pos_reg    <= '0;
            count_reg  <= '0;
        end
        else if (ctrl.advance)
        begin
            scan_reg <= {4'd0, scan_reg[BCD_W-1:4]};
            sum_reg  <= sum_next;
            prev_reg <= digit;
            pos_reg  <= pos_reg + 1'b1;
            // A nonzero digit is the leading one so far.
            if (digit != 4'd0)
            begin
                count_reg  <= pos_reg + 1'b1;
                top_reg    <= digit;
                second_reg <= prev_reg;
            end
        end
    end

    assign status.more     = |scan_reg;
    assign status.count    = count_reg;
    assign status.top      = top_reg;
    assign status.second   = second_reg;
    assign status.sum_zero = (sum_reg == 4'd0);

endmodule
